[sv/sspf_pkg.sv]
// Package for the SPI slave packet framer: payload structs, codes, CRC-8 step.
// No dependencies.
`timescale 1ns / 1ps
package sspf_pkg;
   localparam int BUFFER_DEPTH_DEFAULT = 32;
   localparam logic [7:0] FILL_BYTE = 8'hff;

   localparam logic [2:0] CMD_SELECT   = 3'd0;
   localparam logic [2:0] CMD_EXCHANGE = 3'd1;
   localparam logic [2:0] CMD_DESELECT = 3'd2;
   localparam logic [2:0] CMD_WRITE    = 3'd3;
   localparam logic [2:0] CMD_POST     = 3'd4;
   localparam logic [2:0] CMD_READ     = 3'd5;
   localparam logic [2:0] CMD_RELEASE  = 3'd6;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_HEADER    = 3'd1;
   localparam logic [2:0] ST_LENGTH    = 3'd2;
   localparam logic [2:0] ST_OVERFLOW  = 3'd3;
   localparam logic [2:0] ST_OVERWRITE = 3'd4;
   localparam logic [2:0] ST_CRC       = 3'd5;
   localparam logic [2:0] ST_ACK       = 3'd6;

   localparam logic [2:0] REG_VERSION  = 3'd0;
   localparam logic [2:0] REG_MASK     = 3'd1;
   localparam logic [2:0] REG_PAYLOAD  = 3'd2;
   localparam logic [2:0] REG_BUSY     = 3'd3;
   localparam logic [2:0] REG_PAD_OK   = 3'd4;
   localparam logic [2:0] REG_PAD_ERR  = 3'd5;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] rx_byte;
      logic [4:0] app_index;
      logic [7:0] app_data;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_load;
      logic [2:0] session_status;
      logic       request_ready;
      logic       response_pending;
      logic       notify_master;
      logic [7:0] read_data;
      logic [7:0] request_command;
      logic [4:0] request_length;
   } rsp_type;

   // CRC-8, poly 0x93, MSB first, one byte
   function automatic logic [7:0] crc_next(input logic [7:0] c, input logic [7:0] d);
      logic [7:0] v;
      v = c ^ d;
      for (int i = 0; i < 8; i++) begin
         v = v[7] ? ({v[6:0], 1'b0} ^ 8'h93) : {v[6:0], 1'b0};
      end
      return v;
   endfunction
endpackage

[sv/spi_slave_packet_framer_core.sv]
// SPI slave packet framer top level: request register, framing engine, result register.
// Depends on sspf_pkg and sspf_ram.
`timescale 1ns / 1ps
// Usage: each request carries one command (select, byte exchanged, deselect,
// response write/post, request read/release). Each accepted request yields
// exactly one result: the next transmit byte with its load flag, plus status.
// A request is registered at acceptance; once the result register is free or
// being taken, the engine computes the result (store reads come from the RAM
// port addressed at acceptance) and writes the result register. One request
// is taken every cycle while the receiver does not stall.
// The rate is set by the single engine pass: state update and CRC-8 step sit
// between the request register and the result register.
// When the receiver stalls, the result register holds and the request register
// holds; req_ready drops only while both are full and the result is not taken.
// Synchronous reset clears the phase, counters, flags and status to idle;
// the data stores keep their contents and are only meaningful once written.
// Configuration writes take effect at once; the user must make them while idle, as the block does not enforce it.
module spi_slave_packet_framer_core #(
   parameter int BUFFER_DEPTH = sspf_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sspf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sspf_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [7:0]        csr_data
);
   import sspf_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int RAM_DEPTH = 1 << AW;
   localparam logic [7:0] DEPTH8 = 8'(BUFFER_DEPTH);

   typedef enum logic [4:0] {
      PH_IDLE, PH_HDR, PH_ZEROS, PH_PAD_OK, PH_PAD_ERR, PH_S_KIND, PH_S_BODY,
      PH_S_DONE, PH_R_LEN, PH_R_DATA, PH_R_CRC, PH_R_T1, PH_R_T2, PH_R_T3,
      PH_R_T4, PH_R_T5, PH_A_LEN0, PH_A_LEN, PH_A_CRC, PH_A_DONE
   } phase_type;

   logic [7:0] version_ff, mask_ff, fpay_ff, fbusy_ff, padok_ff, paderr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= 8'd1; mask_ff <= 8'd15; fpay_ff <= 8'd128;
         fbusy_ff <= 8'd64; padok_ff <= 8'd0; paderr_ff <= 8'd255;
      end else if (csr_write) begin
         case (csr_index)
            REG_VERSION: version_ff <= csr_data;
            REG_MASK:    mask_ff <= csr_data;
            REG_PAYLOAD: fpay_ff <= csr_data;
            REG_BUSY:    fbusy_ff <= csr_data;
            REG_PAD_OK:  padok_ff <= csr_data;
            REG_PAD_ERR: paderr_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // stage 1: request register
   logic    s1_valid_ff;
   req_type s1_ff;
   logic    out_full_ff;
   logic    s1_adv;
   assign s1_adv = s1_valid_ff && (!out_full_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;

   phase_type phase_ff, phase_in;
   logic [7:0] count_ff, count_in, crc_run_ff, crc_run_in, crc_rep_ff, crc_rep_in;
   logic [7:0] crc_rx_ff, crc_rx_in, len_rx_ff, len_rx_in, saved_ff, saved_in;
   logic [1:0] hflags_ff, hflags_in;
   logic [5:0] resp_len_ff, resp_len_in;
   logic [7:0] resp_kind_ff, resp_kind_in, req_cmd_ff, req_cmd_in, staged_ff, staged_in;
   logic [5:0] req_len_ff, req_len_in;
   logic       resp_fill_ff, resp_fill_in, req_fill_ff, req_fill_in;
   logic [2:0] pend_ff, pend_in, status_ff, status_in;

   // byte indexes widened to 8 bits for comparison with the depth; the 5-bit index reaches entries 0 to 31
   logic [7:0] idx8, in_idx8;
   assign idx8 = {3'b0, s1_ff.app_index};
   assign in_idx8 = {3'b0, req_data.app_index};

   // request RAM read address is taken from the request being accepted; response RAM read follows the body count
   logic [AW-1:0] resp_rd_addr, req_rd_addr;
   logic [7:0]    resp_rd, req_rd;
   logic [7:0]    body_idx;
   assign body_idx = (phase_in == PH_S_BODY && s1_adv) ? count_in : count_ff;
   // read address looks ahead to next body index: the engine uses count_ff
   // of the pass in which the data is consumed
   logic [AW-1:0] resp_addr_ff;
   always_comb begin
      resp_rd_addr = resp_addr_ff;
      if (s1_adv) resp_rd_addr = body_idx[AW-1:0];
      else if (!s1_valid_ff) resp_rd_addr = count_ff[AW-1:0];
   end
   assign req_rd_addr = req_ready ? in_idx8[AW-1:0] : idx8[AW-1:0];

   logic          resp_we, req_we;
   logic [AW-1:0] resp_wa, req_wa;
   logic [7:0]    req_wd;

   sspf_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_resp_ram (
      .clock(clock), .wr_en(resp_we), .wr_addr(resp_wa), .wr_data(s1_ff.app_data),
      .rd_addr(resp_rd_addr), .rd_data(resp_rd));
   sspf_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_req_ram (
      .clock(clock), .wr_en(req_we), .wr_addr(req_wa), .wr_data(req_wd),
      .rd_addr(req_rd_addr), .rd_data(req_rd));

   // Write-through bypass: a response write in the same pass as a body read
   logic          byp_ff;
   logic [7:0]    byp_data_ff;
   logic [7:0]    body_byte;
   assign body_byte = byp_ff ? byp_data_ff : resp_rd;

   // same for a request byte landing on the entry a read request addresses
   logic          qbyp_ff;
   logic [7:0]    qbyp_data_ff;
   logic [7:0]    req_rd_byte;
   assign req_rd_byte = qbyp_ff ? qbyp_data_ff : req_rd;

   logic       tx_on;
   logic [7:0] tx_val;
   logic [7:0] rd_val;
   logic [7:0] rx;
   assign rx = s1_ff.rx_byte;

   always_comb begin
      phase_in = phase_ff; count_in = count_ff; crc_run_in = crc_run_ff;
      crc_rep_in = crc_rep_ff; crc_rx_in = crc_rx_ff; len_rx_in = len_rx_ff;
      saved_in = saved_ff; hflags_in = hflags_ff; resp_len_in = resp_len_ff;
      resp_kind_in = resp_kind_ff; req_cmd_in = req_cmd_ff; staged_in = staged_ff;
      req_len_in = req_len_ff; resp_fill_in = resp_fill_ff; req_fill_in = req_fill_ff;
      pend_in = pend_ff; status_in = status_ff;
      tx_on = 1'b0; tx_val = 8'd0; rd_val = 8'd0;
      resp_we = 1'b0; resp_wa = idx8[AW-1:0];
      req_we = 1'b0; req_wa = '0; req_wd = rx;
      case (s1_ff.command)
         CMD_SELECT: begin
            hflags_in = {req_fill_ff, resp_fill_ff};
            tx_val = version_ff | (resp_fill_ff ? fpay_ff : 8'd0)
                     | (req_fill_ff ? fbusy_ff : 8'd0);
            tx_on = 1'b1; status_in = ST_OK; phase_in = PH_HDR;
         end
         CMD_EXCHANGE: begin
            case (phase_ff)
               PH_HDR: begin
                  if ((rx & mask_ff) != version_ff) begin
                     tx_on = 1'b1; count_in = 8'd1; pend_in = ST_HEADER; phase_in = PH_ZEROS;
                  end else if ((rx & (fpay_ff | fbusy_ff)) == 8'd0) begin
                     if (!hflags_ff[0]) begin
                        tx_on = 1'b1; count_in = 8'd1; pend_in = ST_OK; phase_in = PH_ZEROS;
                     end else begin
                        len_rx_in = {2'b0, resp_len_ff};
                        tx_on = 1'b1; tx_val = {2'b0, resp_len_ff} + 8'd1;
                        crc_run_in = crc_next(8'd0, tx_val); phase_in = PH_S_KIND;
                     end
                  end else if ((rx & (fpay_ff | fbusy_ff)) == fpay_ff) begin
                     tx_on = 1'b1;
                     if (hflags_ff[1]) begin
                        count_in = 8'd1; pend_in = ST_OVERWRITE; phase_in = PH_ZEROS;
                     end else phase_in = PH_R_LEN;
                  end else if ((rx & (fpay_ff | fbusy_ff)) == fbusy_ff) begin
                     tx_on = 1'b1; tx_val = 8'd2;
                     crc_rep_in = crc_next(8'd0, 8'd2); phase_in = PH_A_LEN0;
                  end else begin
                     tx_on = 1'b1; count_in = 8'd0; pend_in = ST_HEADER; phase_in = PH_ZEROS;
                  end
               end
               PH_ZEROS: begin
                  tx_on = 1'b1;
                  if (count_ff != 8'd0) count_in = count_ff - 8'd1;
                  else begin
                     tx_val = {5'd0, pend_ff}; status_in = pend_ff;
                     phase_in = (pend_ff == ST_OK) ? PH_PAD_OK : PH_PAD_ERR;
                  end
               end
               PH_PAD_OK: begin tx_on = 1'b1; tx_val = padok_ff; end
               PH_PAD_ERR: begin tx_on = 1'b1; tx_val = paderr_ff; end
               PH_S_KIND: begin
                  tx_on = 1'b1; tx_val = resp_kind_ff;
                  crc_run_in = crc_next(crc_run_ff, resp_kind_ff);
                  count_in = 8'd0; phase_in = PH_S_BODY;
               end
               PH_S_BODY: begin
                  tx_on = 1'b1;
                  if (count_ff < len_rx_ff && count_ff < DEPTH8) begin
                     tx_val = body_byte; crc_run_in = crc_next(crc_run_ff, body_byte);
                     count_in = count_ff + 8'd1;
                  end else begin
                     tx_val = crc_run_ff; phase_in = PH_S_DONE;
                  end
               end
               PH_S_DONE: begin
                  saved_in = crc_run_ff; tx_on = 1'b1; tx_val = {5'd0, ST_OK};
                  status_in = ST_OK; phase_in = PH_PAD_OK;
               end
               PH_R_LEN: begin
                  tx_on = 1'b1; crc_rep_in = crc_next(8'd0, 8'd0);
                  if (rx == 8'd0) begin
                     tx_val = {5'd0, ST_LENGTH}; status_in = ST_LENGTH; phase_in = PH_PAD_ERR;
                  end else if (rx >= DEPTH8) begin
                     tx_val = {5'd0, ST_OVERFLOW}; status_in = ST_OVERFLOW;
                     phase_in = PH_PAD_ERR;
                  end else begin
                     len_rx_in = rx; crc_run_in = crc_next(8'd0, rx); count_in = 8'd0;
                     crc_rep_in = crc_next(crc_next(8'd0, 8'd0), 8'd0); phase_in = PH_R_DATA;
                  end
               end
               PH_R_DATA: begin
                  if (count_ff == 8'd0) staged_in = rx;
                  else if (count_ff - 8'd1 < DEPTH8) begin
                     req_we = s1_adv; req_wa = AW'(count_ff - 8'd1);
                  end
                  crc_run_in = crc_next(crc_run_ff, rx); count_in = count_ff + 8'd1;
                  tx_on = 1'b1; crc_rep_in = crc_next(crc_rep_ff, 8'd0);
                  if (count_in >= len_rx_ff) phase_in = PH_R_CRC;
               end
               PH_R_CRC: begin
                  crc_rx_in = rx; tx_on = 1'b1;
                  crc_rep_in = crc_next(crc_rep_ff, 8'd0); phase_in = PH_R_T1;
               end
               PH_R_T1: begin
                  tx_on = 1'b1; tx_val = FILL_BYTE;
                  crc_rep_in = crc_next(crc_rep_ff, FILL_BYTE); phase_in = PH_R_T2;
               end
               PH_R_T2: begin
                  tx_on = 1'b1; tx_val = crc_run_ff;
                  crc_rep_in = crc_next(crc_rep_ff, crc_run_ff); phase_in = PH_R_T3;
               end
               PH_R_T3: begin
                  tx_on = 1'b1; tx_val = crc_rx_ff;
                  crc_rep_in = crc_next(crc_rep_ff, crc_rx_ff); phase_in = PH_R_T4;
               end
               PH_R_T4: begin
                  tx_on = 1'b1; tx_val = crc_rep_ff; phase_in = PH_R_T5;
               end
               PH_R_T5: begin
                  tx_on = 1'b1;
                  if (crc_run_ff != crc_rx_ff) begin
                     tx_val = {5'd0, ST_CRC}; status_in = ST_CRC; phase_in = PH_PAD_ERR;
                  end else begin
                     req_cmd_in = staged_ff; req_len_in = 6'(len_rx_ff - 8'd1);
                     req_fill_in = 1'b1; status_in = ST_OK; phase_in = PH_PAD_OK;
                  end
               end
               PH_A_LEN0: begin
                  count_in = {2'b0, resp_len_ff} + 8'd1; tx_on = 1'b1; tx_val = count_in;
                  crc_rep_in = crc_next(crc_rep_ff, count_in); phase_in = PH_A_LEN;
               end
               PH_A_LEN: begin
                  len_rx_in = rx; tx_on = 1'b1; tx_val = saved_ff;
                  crc_rep_in = crc_next(crc_rep_ff, saved_ff); phase_in = PH_A_CRC;
               end
               PH_A_CRC: begin
                  crc_rx_in = rx; tx_on = 1'b1; tx_val = crc_rep_ff; phase_in = PH_A_DONE;
               end
               PH_A_DONE: begin
                  tx_on = 1'b1;
                  if (count_ff == len_rx_ff && saved_ff == crc_rx_ff) begin
                     resp_fill_in = 1'b0; resp_len_in = '0; resp_kind_in = '0;
                     tx_val = {5'd0, ST_OK}; status_in = ST_OK; phase_in = PH_PAD_OK;
                  end else begin
                     tx_val = {5'd0, ST_ACK}; status_in = ST_ACK; phase_in = PH_PAD_ERR;
                  end
               end
               default: ;
            endcase
         end
         CMD_DESELECT: phase_in = PH_IDLE;
         CMD_WRITE: resp_we = s1_adv && (idx8 < DEPTH8);
         CMD_POST: begin
            resp_len_in = (idx8 > DEPTH8) ? DEPTH8[5:0] : idx8[5:0];
            resp_kind_in = s1_ff.app_data; resp_fill_in = 1'b1;
         end
         CMD_READ: if (idx8 < DEPTH8) rd_val = req_rd_byte;
         CMD_RELEASE: req_fill_in = 1'b0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0; out_full_ff <= 1'b0; phase_ff <= PH_IDLE;
         count_ff <= '0; crc_run_ff <= '0; crc_rep_ff <= '0; crc_rx_ff <= '0;
         len_rx_ff <= '0; saved_ff <= '0; hflags_ff <= '0; resp_len_ff <= '0;
         resp_kind_ff <= '0; req_cmd_ff <= '0; staged_ff <= '0; req_len_ff <= '0;
         resp_fill_ff <= 1'b0; req_fill_ff <= 1'b0; pend_ff <= ST_OK; status_ff <= ST_OK;
         byp_ff <= 1'b0; qbyp_ff <= 1'b0;
      end else begin
         if (req_ready) s1_valid_ff <= req_valid;
         if (s1_adv) out_full_ff <= 1'b1;
         else if (rsp_ready) out_full_ff <= 1'b0;
         if (s1_adv) begin
            phase_ff <= phase_in; count_ff <= count_in; crc_run_ff <= crc_run_in;
            crc_rep_ff <= crc_rep_in; crc_rx_ff <= crc_rx_in; len_rx_ff <= len_rx_in;
            saved_ff <= saved_in; hflags_ff <= hflags_in; resp_len_ff <= resp_len_in;
            resp_kind_ff <= resp_kind_in; req_cmd_ff <= req_cmd_in; staged_ff <= staged_in;
            req_len_ff <= req_len_in; resp_fill_ff <= resp_fill_in;
            req_fill_ff <= req_fill_in; pend_ff <= pend_in; status_ff <= status_in;
         end
         // a write to the entry being read this cycle forwards its data
         byp_ff <= resp_we && (resp_wa == resp_rd_addr);
         qbyp_ff <= req_we && (req_wa == req_rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) s1_ff <= req_data;
      byp_data_ff <= s1_ff.app_data;
      qbyp_data_ff <= req_wd;
      resp_addr_ff <= resp_rd_addr;
      if (s1_adv) begin
         rsp_data.tx_byte <= tx_on ? tx_val : 8'd0;
         rsp_data.tx_load <= tx_on;
         rsp_data.session_status <= status_in;
         rsp_data.request_ready <= req_fill_in;
         rsp_data.response_pending <= resp_fill_in;
         rsp_data.notify_master <= resp_fill_in && (phase_in == PH_IDLE);
         rsp_data.read_data <= rd_val;
         rsp_data.request_command <= req_cmd_in;
         rsp_data.request_length <= req_len_in[4:0];
      end
   end
   assign rsp_valid = out_full_ff;

   // the stores are written only with writes that really complete
   assert property (@(posedge clock) disable iff (reset) req_we |-> s1_adv)
      else $error("request store written without advance");
   assert property (@(posedge clock) disable iff (reset)
      (out_full_ff && !rsp_ready) |=> $stable(rsp_data))
      else $error("stalled result changed");
   assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_ff.command == CMD_SELECT) |=> rsp_data.tx_load)
      else $error("select without header load");
   assert property (@(posedge clock) disable iff (reset)
      (req_fill_ff && s1_adv) |-> !req_we)
      else $error("request store overwritten while request waits");
endmodule

[sv/sspf_ram.sv]
// Generic single-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module sspf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
